// ===== hdl/rsig_pkg.sv =====
// Package for the random smooth intensity generator: widths, constants,
// register indexes, sequencer states and small arithmetic helpers.
// No dependencies.
package rsig_pkg;

    // Field and datapath widths
    localparam int unsigned NUM_POINTS = 4;
    localparam int unsigned LVL_W      = 16;
    localparam int unsigned TIME_W     = 16;
    localparam int unsigned ACC_W      = 32;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned PAIR_W     = 17;
    localparam int unsigned SUM_W      = 19;
    localparam int unsigned QUO_W      = 18;
    localparam int unsigned MUL_A_W    = 32;
    localparam int unsigned MUL_B_W    = 19;
    localparam int unsigned PROD_W     = MUL_A_W + MUL_B_W;
    localparam int unsigned CNT_W      = 5;

    // Intensity constants, Q2.14
    localparam logic [LVL_W-1:0] ONE_Q14    = 16'd16384;
    localparam logic [LVL_W-1:0] FULL_SCALE = 16'hFFFF;

    // floor(2^21 / 7): reciprocal for dividing the point sum by seven
    localparam logic [MUL_B_W-1:0] RECIP7       = 19'd299593;
    localparam int unsigned        RECIP7_SHIFT = 21;

    // Register reset values
    localparam logic [LVL_W-1:0]  RST_INTENSITY_MIN   = 16'd0;
    localparam logic [LVL_W-1:0]  RST_INTENSITY_MAX   = 16'd16384;
    localparam logic [TIME_W-1:0] RST_PERIOD_MIN      = 16'd1000;
    localparam logic [TIME_W-1:0] RST_PERIOD_MAX      = 16'd5000;
    localparam logic [LVL_W-1:0]  RST_INTENSITY_START = 16'd16384;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GEN_ENABLE      = 3'd0,
        CFG_INTENSITY_MIN   = 3'd1,
        CFG_INTENSITY_MAX   = 3'd2,
        CFG_PERIOD_MIN      = 3'd3,
        CFG_PERIOD_MAX      = 3'd4,
        CFG_INTENSITY_START = 3'd5
    } cfg_idx_t;

    // Sequencer states, one-hot
    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_ACCUM = 12'b0000_0000_0010,
        ST_LEVEL = 12'b0000_0000_0100,
        ST_SUM   = 12'b0000_0000_1000,
        ST_RECIP = 12'b0000_0001_0000,
        ST_DIV7  = 12'b0000_0010_0000,
        ST_BLEND = 12'b0000_0100_0000,
        ST_MULT  = 12'b0000_1000_0000,
        ST_CHECK = 12'b0001_0000_0000,
        ST_DIV   = 12'b0010_0000_0000,
        ST_FIN   = 12'b0100_0000_0000,
        ST_OUT   = 12'b1000_0000_0000
    } state_t;

    // Distance between two 16-bit limits
    function automatic logic [LVL_W-1:0] span16(input logic [LVL_W-1:0] lo,
                                                 input logic [LVL_W-1:0] hi);
        return (hi >= lo) ? (hi - lo) : (lo - hi);
    endfunction

    // floor(p / 65535) for p below 65535 * 65536
    function automatic logic [LVL_W-1:0] div_full_scale(input logic [31:0] p);
        logic [32:0] t;
        t = {1'b0, p} + 33'(p[31:16]) + 33'd1;
        return t[31:16];
    endfunction

    // Random draw from lo toward hi, given the product r * |hi - lo|
    function automatic logic [LVL_W-1:0] draw_between(input logic [LVL_W-1:0] lo,
                                                       input logic [LVL_W-1:0] hi,
                                                       input logic [31:0] prod);
        logic [LVL_W-1:0] q;
        q = div_full_scale(prod);
        return (hi >= lo) ? (lo + q) : (lo - q);
    endfunction

endpackage

// ===== hdl/random_smooth_intensity_generator.sv =====
// Random smooth intensity generator, top level.
// Depends on rsig_pkg. Holds the sequencer, the shared multiplier and the
// shift-subtract divider.
//
// Each accepted tick yields one intensity: ONE_Q14 when disabled, else a
// smoothed value, posted once the output register is free. When a segment
// ends, a new control point and period are drawn first. A zero period skips
// the multiply and the division; a blend far out of range skips the division.
// The blend uses the 18-step restoring divider for time * (b - a) / period
// and the single shared 32x19 multiplier, which the random draws, the
// divide-by-seven and the blend product take in turn.
// A new tick is taken only when the sequencer is idle, which it re-enters as
// it posts the previous result; a finished result waits in the output register
// without holding up the next tick.
module random_smooth_intensity_generator (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [rsig_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [rsig_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [rsig_pkg::TIME_W-1:0]     s_elapsed_ms,
    input  logic [rsig_pkg::LVL_W-1:0]      s_random_word,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [rsig_pkg::LVL_W-1:0]      m_intensity
);
    import rsig_pkg::*;

    // Control and architectural state
    state_t             state_reg, state_next;
    logic               m_valid_reg, m_valid_next;
    logic               gen_enable_reg, gen_enable_next;
    logic [LVL_W-1:0]   imin_reg, imin_next;
    logic [LVL_W-1:0]   imax_reg, imax_next;
    logic [TIME_W-1:0]  pmin_reg, pmin_next;
    logic [TIME_W-1:0]  pmax_reg, pmax_next;
    logic [LVL_W-1:0]   pt_reg [NUM_POINTS];
    logic [LVL_W-1:0]   pt_next [NUM_POINTS];
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [TIME_W-1:0]  period_reg, period_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    // Datapath payload
    logic [TIME_W-1:0]  dt_reg, dt_next;
    logic [LVL_W-1:0]   r_reg, r_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [LVL_W-1:0]   level_reg, level_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [PAIR_W-1:0]  a_reg, a_next;
    logic [PAIR_W-1:0]  diff_reg, diff_next;
    logic               neg_reg, neg_next;
    logic [LVL_W-1:0]   rem_reg, rem_next;
    logic [QUO_W-1:0]   qsh_reg, qsh_next;
    logic [LVL_W-1:0]   res_reg, res_next;
    logic [LVL_W-1:0]   m_intensity_reg, m_intensity_next;

    // Shared multiplier operands
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;

    // Combinational helpers
    logic [ACC_W:0]     acc_sum;
    logic [ACC_W-1:0]   acc_sat;
    logic [17:0]        pts3;
    logic [16:0]        q7_est;
    logic [SUM_W:0]     rem7;
    logic [PAIR_W-1:0]  pair_a;
    logic [PAIR_W-1:0]  pair_b;
    logic [32:0]        prod_hi;
    logic [LVL_W:0]     rem_shift;
    logic [LVL_W:0]     rem_sub;
    logic               rem_ge;
    logic [SUM_W-1:0]   blend_pos;
    logic [QUO_W-1:0]   blend_neg;

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_intensity = m_intensity_reg;

    // Saturating time accumulation
    assign acc_sum = {1'b0, acc_reg} + (ACC_W + 1)'(dt_reg);
    assign acc_sat = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];

    // Weighted sum pieces and divide-by-seven correction
    assign pts3   = 18'(pt_reg[1]) + 18'(pt_reg[2]) + 18'(pt_reg[3]);
    assign q7_est = prod_reg[RECIP7_SHIFT+16:RECIP7_SHIFT];
    assign rem7   = {1'b0, sum_reg} - ((SUM_W + 1)'({q7_est, 3'b000}) -
                                       (SUM_W + 1)'(q7_est));

    // Blend end points
    assign pair_a = PAIR_W'(pt_reg[0]) + PAIR_W'(pt_reg[1]);
    assign pair_b = PAIR_W'(pt_reg[2]) + PAIR_W'(pt_reg[3]);

    // Divider range check and one restoring step
    assign prod_hi   = prod_reg[PROD_W-1:QUO_W];
    assign rem_shift = {rem_reg, qsh_reg[QUO_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, period_reg};
    assign rem_sub   = rem_shift - {1'b0, period_reg};

    // Final blend from the quotient
    assign blend_pos = SUM_W'(a_reg) + SUM_W'(qsh_reg);
    assign blend_neg = QUO_W'(a_reg) - qsh_reg;

    // Select multiplier operands by step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_ACCUM: begin
                mul_a = MUL_A_W'(r_reg);
                mul_b = MUL_B_W'(span16(imin_reg, imax_reg));
            end
            ST_LEVEL: begin
                mul_a = MUL_A_W'(r_reg);
                mul_b = MUL_B_W'(span16(pmin_reg, pmax_reg));
            end
            ST_RECIP: begin
                mul_a = MUL_A_W'(sum_reg);
                mul_b = RECIP7;
            end
            ST_MULT: begin
                mul_a = acc_reg;
                mul_b = MUL_B_W'(diff_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Sequencer and datapath next state
    always_comb begin
        state_next       = state_reg;
        m_valid_next     = m_valid_reg;
        gen_enable_next  = gen_enable_reg;
        imin_next        = imin_reg;
        imax_next        = imax_reg;
        pmin_next        = pmin_reg;
        pmax_next        = pmax_reg;
        pt_next          = pt_reg;
        acc_next         = acc_reg;
        period_next      = period_reg;
        cnt_next         = cnt_reg;
        dt_next          = dt_reg;
        r_next           = r_reg;
        prod_next        = PROD_W'(mul_a) * PROD_W'(mul_b);
        level_next       = level_reg;
        sum_next         = sum_reg;
        a_next           = a_reg;
        diff_next        = diff_reg;
        neg_next         = neg_reg;
        rem_next         = rem_reg;
        qsh_next         = qsh_reg;
        res_next         = res_reg;
        m_intensity_next = m_intensity_reg;

        // Drop the result once the consumer takes it
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    dt_next = s_elapsed_ms;
                    r_next  = s_random_word;
                    if (gen_enable_reg) begin
                        state_next = ST_ACCUM;
                    end else begin
                        res_next   = ONE_Q14;
                        state_next = ST_OUT;
                    end
                end
            end
            ST_ACCUM: begin
                acc_next   = acc_sat;
                state_next = (acc_sat > ACC_W'(period_reg)) ? ST_LEVEL : ST_BLEND;
            end
            ST_LEVEL: begin
                level_next = draw_between(imin_reg, imax_reg, prod_reg[31:0]);
                state_next = ST_SUM;
            end
            ST_SUM: begin
                sum_next    = {pts3, 1'b0} + SUM_W'(level_reg);
                acc_next    = acc_reg - ACC_W'(period_reg);
                period_next = draw_between(pmin_reg, pmax_reg, prod_reg[31:0]);
                state_next  = ST_RECIP;
            end
            ST_RECIP: begin
                state_next = ST_DIV7;
            end
            ST_DIV7: begin
                // Advance the ring: the new point lands at the far end
                for (int i = 0; i < NUM_POINTS - 1; i++) begin
                    pt_next[i] = pt_reg[i+1];
                end
                pt_next[NUM_POINTS-1] = q7_est[LVL_W-1:0] +
                                        LVL_W'(rem7 >= (SUM_W + 1)'(7));
                state_next = ST_BLEND;
            end
            ST_BLEND: begin
                a_next    = pair_a;
                neg_next  = pair_b < pair_a;
                diff_next = (pair_b < pair_a) ? (pair_a - pair_b) : (pair_b - pair_a);
                if (period_reg == '0) begin
                    res_next   = pair_a[PAIR_W-1:1];
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_MULT;
                end
            end
            ST_MULT: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                // Quotient of 2^18 or more drives the output to a rail
                if (prod_hi >= 33'(period_reg)) begin
                    res_next   = neg_reg ? '0 : FULL_SCALE;
                    state_next = ST_OUT;
                end else begin
                    rem_next   = prod_hi[LVL_W-1:0];
                    qsh_next   = prod_reg[QUO_W-1:0];
                    cnt_next   = CNT_W'(QUO_W - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next = rem_ge ? rem_sub[LVL_W-1:0] : rem_shift[LVL_W-1:0];
                qsh_next = {qsh_reg[QUO_W-2:0], rem_ge};
                if (cnt_reg == '0) begin
                    state_next = ST_FIN;
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_FIN: begin
                if (!neg_reg) begin
                    res_next = (blend_pos[SUM_W-1:1] > QUO_W'(FULL_SCALE)) ?
                               FULL_SCALE : blend_pos[LVL_W:1];
                end else if (QUO_W'(a_reg) <= qsh_reg) begin
                    res_next = '0;
                end else begin
                    res_next = blend_neg[LVL_W:1];
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next     = 1'b1;
                    m_intensity_next = res_reg;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Configuration writes
        if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_GEN_ENABLE:    gen_enable_next = cfg_wdata[0];
                CFG_INTENSITY_MIN: imin_next       = cfg_wdata;
                CFG_INTENSITY_MAX: imax_next       = cfg_wdata;
                CFG_PERIOD_MIN:    pmin_next       = cfg_wdata;
                CFG_PERIOD_MAX:    pmax_next       = cfg_wdata;
                CFG_INTENSITY_START: begin
                    for (int i = 0; i < NUM_POINTS; i++) begin
                        pt_next[i] = cfg_wdata;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Control and architectural registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            gen_enable_reg <= 1'b0;
            imin_reg       <= RST_INTENSITY_MIN;
            imax_reg       <= RST_INTENSITY_MAX;
            pmin_reg       <= RST_PERIOD_MIN;
            pmax_reg       <= RST_PERIOD_MAX;
            for (int i = 0; i < NUM_POINTS; i++) begin
                pt_reg[i] <= RST_INTENSITY_START;
            end
            acc_reg        <= '0;
            period_reg     <= '0;
            cnt_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            gen_enable_reg <= gen_enable_next;
            imin_reg       <= imin_next;
            imax_reg       <= imax_next;
            pmin_reg       <= pmin_next;
            pmax_reg       <= pmax_next;
            pt_reg         <= pt_next;
            acc_reg        <= acc_next;
            period_reg     <= period_next;
            cnt_reg        <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        dt_reg          <= dt_next;
        r_reg           <= r_next;
        prod_reg        <= prod_next;
        level_reg       <= level_next;
        sum_reg         <= sum_next;
        a_reg           <= a_next;
        diff_reg        <= diff_next;
        neg_reg         <= neg_next;
        rem_reg         <= rem_next;
        qsh_reg         <= qsh_next;
        res_reg         <= res_next;
        m_intensity_reg <= m_intensity_next;
    end

`ifndef ASSERT_OFF
    // A transaction in starts a busy stretch
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted on consecutive cycles");

    // The divider only runs against a nonzero period
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (period_reg != '0))
        else $error("division started with zero period");

    // The partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < period_reg))
        else $error("divider remainder out of range");

    // Leaving the output step always posts a result and frees the input
    a_out_posts: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) && (!m_valid_reg || m_ready) |=> m_valid_reg && s_ready)
        else $error("result not posted from output step");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for random_smooth_intensity_generator.
// Depends on rsig_pkg and the generator RTL; predicts each intensity from a
// local mirror of the control point ring and checks every result in order.
module testbench;

    import rsig_pkg::*;

    // Spare register indexes that the block must ignore
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int IDLE_PCT     = 23;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 3000;
    localparam int REPORT_LIMIT = 10;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic [TIME_W-1:0]     s_elapsed_ms;
    logic [LVL_W-1:0]      s_random_word;
    logic                  m_valid;
    logic                  m_ready;
    logic [LVL_W-1:0]      m_intensity;

    // Mirror of the block: configuration and smoothing state
    logic              gen_on;
    logic [LVL_W-1:0]  lvl_lo, lvl_hi;
    logic [TIME_W-1:0] per_lo, per_hi;
    logic [LVL_W-1:0]  cp_level [NUM_POINTS];
    logic [1:0]        cp_head;
    logic [ACC_W-1:0]  acc_ms;
    logic [TIME_W-1:0] seg_period;

    logic [LVL_W-1:0] pending_intensity [$];
    logic [LVL_W-1:0] want_intensity;
    int               mismatch_count;
    int               stall_cycles;
    bit               no_gaps;
    bit               hold_req;

    random_smooth_intensity_generator u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_elapsed_ms  (s_elapsed_ms),
        .s_random_word (s_random_word),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_intensity   (m_intensity)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // Draw from lo toward hi, truncating toward lo
    function automatic logic [LVL_W-1:0] scaled_draw(input logic [LVL_W-1:0] lo,
                                                      input logic [LVL_W-1:0] hi,
                                                      input logic [LVL_W-1:0] r);
        longint unsigned span;
        span = r;
        if (hi >= lo) begin
            span = span * (hi - lo) / FULL_SCALE;
            return lo + 16'(span);
        end
        span = span * (lo - hi) / FULL_SCALE;
        return lo - 16'(span);
    endfunction

    function automatic logic [LVL_W-1:0] pt_at(input logic [1:0] offset);
        logic [1:0] slot;
        slot = cp_head + offset;
        return cp_level[slot];
    endfunction

    // Advance the mirror by one tick and return the intensity it yields
    function automatic logic [LVL_W-1:0] next_intensity(input logic [TIME_W-1:0] dt,
                                                         input logic [LVL_W-1:0] r);
        logic [LVL_W-1:0] level;
        int unsigned      pt_sum, a_pair, b_pair;
        longint unsigned  span;
        if (!gen_on)
            return ONE_Q14;
        // Saturate the accumulator instead of wrapping
        if (acc_ms > 32'hFFFF_FFFF - dt)
            acc_ms = '1;
        else
            acc_ms = acc_ms + dt;
        // Segment over: replace the oldest point, rotate, draw a new period
        if (acc_ms > seg_period) begin
            level  = scaled_draw(lvl_lo, lvl_hi, r);
            pt_sum = pt_at(2'd1);
            pt_sum = pt_sum + pt_at(2'd2) + pt_at(2'd3);
            pt_sum = 2 * pt_sum + level;
            // weights 2,2,2,1 sum to seven
            cp_level[cp_head] = 16'(pt_sum / 7);
            cp_head    = cp_head + 2'd1;
            acc_ms     = acc_ms - seg_period;
            seg_period = scaled_draw(per_lo, per_hi, r);
        end
        a_pair = pt_at(2'd0);
        a_pair = a_pair + pt_at(2'd1);
        b_pair = pt_at(2'd2);
        b_pair = b_pair + pt_at(2'd3);
        if (seg_period == 0)
            return 16'(a_pair / 2);
        span = acc_ms;
        if (b_pair >= a_pair) begin
            span = span * (b_pair - a_pair) / seg_period;
            span = (span + a_pair) / 2;
            return (span > FULL_SCALE) ? FULL_SCALE : 16'(span);
        end
        span = span * (a_pair - b_pair) / seg_period;
        if (span >= a_pair)
            return '0;
        return 16'((a_pair - span) / 2);
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] addr,
                                      input logic [CFG_DATA_W-1:0] data);
        case (addr)
            CFG_GEN_ENABLE:      gen_on = data[0];
            CFG_INTENSITY_MIN:   lvl_lo = data;
            CFG_INTENSITY_MAX:   lvl_hi = data;
            CFG_PERIOD_MIN:      per_lo = data;
            CFG_PERIOD_MAX:      per_hi = data;
            CFG_INTENSITY_START: begin
                for (int i = 0; i < NUM_POINTS; i++)
                    cp_level[i] = data;
            end
            default: ;
        endcase
    endfunction

    function automatic bit take_gap();
        return !no_gaps && ($urandom_range(99) < IDLE_PCT);
    endfunction

    function automatic logic [TIME_W-1:0] random_dt();
        case ($urandom_range(3))
            0:       return 16'($urandom_range(63));
            1:       return 16'($urandom_range(2047));
            2:       return 16'($urandom_range(16'hFFFF));
            default: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    // Write one register; only called while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_we <= 1'b0;
        apply_reg(addr, data);
    endtask

    task automatic program_levels(input logic [LVL_W-1:0] lo, input logic [LVL_W-1:0] hi,
                                  input logic [TIME_W-1:0] plo, input logic [TIME_W-1:0] phi,
                                  input logic [LVL_W-1:0] start);
        write_reg(CFG_INTENSITY_MIN, lo);
        write_reg(CFG_INTENSITY_MAX, hi);
        write_reg(CFG_PERIOD_MIN, plo);
        write_reg(CFG_PERIOD_MAX, phi);
        write_reg(CFG_INTENSITY_START, start);
    endtask

    // Offer one tick, hold it until accepted, then record its expected intensity
    task automatic send_tick(input logic [TIME_W-1:0] dt, input logic [LVL_W-1:0] r);
        @(negedge aclk);
        while (take_gap()) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_elapsed_ms  <= dt;
        s_random_word <= r;
        do @(posedge aclk); while (!s_ready);
        pending_intensity.push_back(next_intensity(dt, r));
    endtask

    // Drop valid and wait for every outstanding result
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_intensity.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic test_disabled();
        send_tick(16'h0000, 16'h0000);
        send_tick(16'hFFFF, 16'hFFFF);
        send_tick(16'h1234, 16'h4321);
        settle();
    endtask

    task automatic test_directed();
        write_reg(CFG_GEN_ENABLE, 16'h0001);
        // Zero period and no time yet, then time that ends the zero-length segment
        send_tick(16'h0000, 16'h0000);
        send_tick(16'h0001, 16'hFFFF);
        // Far past the period: one update, then extrapolate
        send_tick(16'hFFFF, 16'h0000);
        send_tick(16'h0000, 16'h5555);
        send_tick(16'h00FF, 16'hAAAA);
        settle();
        // Top of the level range everywhere
        program_levels(16'hFFFF, 16'hFFFF, 16'h0001, 16'hFFFF, 16'hFFFF);
        send_tick(16'hFFFF, 16'hFFFF);
        send_tick(16'hFFFF, 16'h0000);
        send_tick(16'h0000, 16'h0000);
        settle();
        // Reversed limits for both level and period
        program_levels(16'd60000, 16'd100, 16'd4000, 16'd10, 16'h0000);
        send_tick(16'd3000, 16'hFFFF);
        send_tick(16'd5000, 16'd8000);
        send_tick(16'h0001, 16'h0000);
        send_tick(16'hFFFF, 16'd1234);
        settle();
        // Period pinned at zero
        write_reg(CFG_PERIOD_MIN, 16'h0000);
        write_reg(CFG_PERIOD_MAX, 16'h0000);
        send_tick(16'h0000, 16'h8000);
        send_tick(16'h0007, 16'h7FFF);
        send_tick(16'h0000, 16'hC3A5);
        settle();
        // Spare indexes must not disturb anything
        write_reg(CFG_SPARE_LO, 16'hFFFF);
        write_reg(CFG_SPARE_HI, 16'h0000);
        send_tick(16'd100, 16'd100);
        settle();
        // Only bit zero of the enable counts
        write_reg(CFG_GEN_ENABLE, 16'hFFFE);
        send_tick(16'hFFFF, 16'hFFFF);
        settle();
        write_reg(CFG_GEN_ENABLE, 16'h0001);
        send_tick(16'd50, 16'h0F0F);
        settle();
    endtask

    task automatic test_random_settings(input int n_items);
        int per_phase;
        per_phase = n_items / 6;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: program_levels(16'($urandom_range(16384)), 16'($urandom_range(32768, 16384)),
                                  16'($urandom_range(1000, 100)), 16'($urandom_range(4000, 1000)),
                                  16'($urandom_range(16'hFFFF)));
                1: program_levels(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF);
                2: program_levels(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h0000);
                3: program_levels(16'($urandom), 16'($urandom), 16'd1, 16'd64, 16'($urandom));
                4: program_levels(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom));
                default: program_levels(16'($urandom), 16'($urandom), 16'h0000, 16'h0000,
                                        16'($urandom));
            endcase
            write_reg(CFG_GEN_ENABLE, 16'($urandom) | 16'h0001);
            // Run one phase without any idling on either side
            no_gaps = (phase == 1);
            for (int i = 0; i < per_phase; i++)
                send_tick(random_dt(), 16'($urandom));
            settle();
        end
        no_gaps = 1'b0;
    endtask

    // Stall the result side long enough that the input backs up
    task automatic test_backpressure(input int n_items);
        program_levels(16'd2000, 16'd40000, 16'd10, 16'd300, 16'd20000);
        hold_req = 1'b1;
        for (int i = 0; i < n_items; i++)
            send_tick(16'($urandom_range(400)), 16'($urandom));
        settle();
    endtask

    // Pin the period at zero and feed full ticks so the accumulator grows large
    task automatic test_accum_saturation();
        write_reg(CFG_PERIOD_MIN, 16'h0000);
        write_reg(CFG_PERIOD_MAX, 16'h0000);
        no_gaps = 1'b1;
        repeat (20) send_tick(16'hFFFF, 16'($urandom));
        settle();
        no_gaps = 1'b0;
        // Huge accumulated time against a real period: extrapolate and clamp
        program_levels(16'h0000, 16'hFFFF, 16'h0001, 16'hFFFF, 16'($urandom));
        repeat (10) send_tick(random_dt(), 16'($urandom));
        settle();
    endtask

    // Result side: random stalls, or one long hold when asked
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
                m_ready <= 1'b1;
            end else begin
                m_ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_intensity.size() == 0) begin
                if (mismatch_count < REPORT_LIMIT)
                    $display("%0t: intensity %0d arrived with nothing pending",
                             $time, m_intensity);
                mismatch_count++;
            end else begin
                want_intensity = pending_intensity.pop_front();
                if (m_intensity !== want_intensity) begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("%0t: intensity expected %0d got %0d",
                                 $time, want_intensity, m_intensity);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_addr       = CFG_GEN_ENABLE;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_elapsed_ms   = '0;
        s_random_word  = '0;
        mismatch_count = 0;
        no_gaps        = 1'b0;
        hold_req       = 1'b0;
        // Mirror starts from the register reset values
        gen_on     = 1'b0;
        lvl_lo     = RST_INTENSITY_MIN;
        lvl_hi     = RST_INTENSITY_MAX;
        per_lo     = RST_PERIOD_MIN;
        per_hi     = RST_PERIOD_MAX;
        cp_head    = '0;
        acc_ms     = '0;
        seg_period = '0;
        for (int i = 0; i < NUM_POINTS; i++)
            cp_level[i] = RST_INTENSITY_START;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_disabled();
        test_directed();
        test_random_settings(600);
        test_backpressure(40);
        test_accum_saturation();
        settle();

        if (pending_intensity.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/rsig_pkg.sv
hdl/random_smooth_intensity_generator.sv
tb/testbench.sv
